/* rtl/rsr_pkg.sv */
// Shared package for the radial surface relaxation block.
// Holds field widths, register indexes, mode codes and fixed-point constants.
// No dependencies.
package rsr_pkg;

  localparam int POS_W       = 32;
  localparam int SUM_W       = 2 * POS_W;
  localparam int ROOT_W      = POS_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int COORD_WIDTH_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DECAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_NUMBER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNIFORM_SCALE = 3'd5;

  localparam logic [1:0] MODE_EXP     = 2'd0;
  localparam logic [1:0] MODE_OSC     = 2'd1;
  localparam logic [1:0] MODE_UNIFORM = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [30:0] LOG2E_Q30      = 31'd1549082005;
  localparam logic [24:0] EXP_BIAS       = 25'd2337507;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [15:0] EXP_C1         = 16'd45600;
  localparam logic [14:0] EXP_C2         = 15'd14752;
  localparam logic [12:0] EXP_C3         = 13'd5184;
  localparam logic [16:0] SIN_A1         = 17'd102944;
  localparam logic [15:0] SIN_A3         = 16'd42166;
  localparam logic [12:0] SIN_A5         = 13'd4758;
  localparam logic [22:0] EXP_ARG_LIMIT  = 23'd4194304;
  localparam logic [16:0] ONE_Q16        = 17'd65536;
  localparam logic [8:0]  EXP_N_BIAS     = 9'd128;

  typedef struct packed {
    logic [2:0][POS_W-1:0] c;
    logic                  last;
  } side_t;

endpackage

/* rtl/rsr_in_if.sv */
// Input channel of the radial surface relaxation block: one atom position.
// Depends on rsr_pkg.
interface rsr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsr_pkg::POS_W-1:0]  pos_x;
  logic signed [rsr_pkg::POS_W-1:0]  pos_y;
  logic signed [rsr_pkg::POS_W-1:0]  pos_z;
  logic                              last_atom;

  modport source (output valid, pos_x, pos_y, pos_z, last_atom, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_atom, output ready);
endinterface

/* rtl/rsr_out_if.sv */
// Result channel of the radial surface relaxation block: displaced position.
// Depends on rsr_pkg.
interface rsr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsr_pkg::POS_W-1:0]  new_x;
  logic signed [rsr_pkg::POS_W-1:0]  new_y;
  logic signed [rsr_pkg::POS_W-1:0]  new_z;
  logic                              final_atom;
  logic                              saturated;

  modport source (output valid, new_x, new_y, new_z, final_atom, saturated, input ready);
  modport sink   (input valid, new_x, new_y, new_z, final_atom, saturated, output ready);
endinterface

/* rtl/rsr_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Standalone; every stage advances only on en.
module rsr_sqrt #(
  parameter int IN_W = rsr_pkg::SUM_W
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   radicand,
  output logic [IN_W/2-1:0] root
);

  localparam int STEPS = IN_W / 2;
  localparam int REM_W = STEPS + 3;

  logic [IN_W-1:0]  v_r    [STEPS-1];
  logic [REM_W-1:0] rem_r  [STEPS-1];
  logic [STEPS-1:0] root_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [IN_W-1:0]  v_in;
    logic [REM_W-1:0] rem_in;
    logic [STEPS-1:0] root_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], v_in[IN_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[STEPS-2:0], ge};
      end
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          v_r[k]   <= {v_in[IN_W-3:0], 2'b00};
          rem_r[k] <= ge ? rem_sh - trial : rem_sh;
        end
      end
    end
  end

  assign root = root_r[STEPS-1];

endmodule

/* rtl/rsr_div.sv */
// Pipelined restoring divider: quot = (numer << (W-1)) / denom, numer <= denom.
// Standalone; one quotient bit per stage, and every stage advances only on en.
module rsr_div #(
  parameter int W = rsr_pkg::POS_W
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] numer,
  input  logic [W-1:0] denom,
  output logic [W-1:0] quot
);

  logic [W-1:0] rem_r  [W-1];
  logic [W-1:0] den_r  [W-1];
  logic [W-1:0] quot_r [W];

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W-1:0] rem_in;
    logic [W-1:0] den_in;
    logic [W-1:0] q_in;
    logic         bit_in;
    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, numer[W-1:1]};
      assign den_in = denom;
      assign q_in   = '0;
      assign bit_in = numer[0];
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = quot_r[k-1];
      assign bit_in = 1'b0;
    end

    assign rem_sh = {rem_in, bit_in};
    assign diff   = rem_sh - {1'b0, den_in};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        quot_r[k] <= {q_in[W-2:0], ge};
      end
    end

    if (k < W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[W-1:0] : rem_sh[W-1:0];
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quot = quot_r[W-1];

endmodule

/* rtl/radial_surface_relaxation.sv */
// Radial surface relaxation: displaces atom positions radially or by a uniform scale.
// Depends on rsr_pkg, rsr_in_if, rsr_out_if, rsr_sqrt and rsr_div.
//
//   Channel   Direction  Carries                                     Handshake
//   in_ch     sink       pos_x, pos_y, pos_z, last_atom              valid/ready
//   out_ch    source     new_x, new_y, new_z, final_atom, saturated  valid/ready
//   cfg_*     write      cfg_index, cfg_wdata                        cfg_we
//
// One position enters per cycle while the output register is empty or taken.
// The pipe holds the 32-stage square root followed by the 32-stage dividers
// that form c/r, one bit per stage each.
// Every stage advances together whenever the output register is empty or taken;
// a stall holds the whole pipe, so nothing is dropped or repeated.
// rst_n (synchronous) clears the valid bits and loads the register defaults.
module radial_surface_relaxation #(
  parameter int COORD_WIDTH = rsr_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rsr_in_if.sink                          in_ch,
  rsr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PW = rsr_pkg::POS_W;
  localparam int RW = rsr_pkg::ROOT_W;

  // Stage numbers (register stage holding the named value)
  localparam int S_SUM  = 4;
  localparam int S_ROOT = S_SUM + RW;
  localparam int S_DIFF = S_ROOT + 1;
  localparam int S_MAG  = S_ROOT + 2;
  localparam int S_ARG  = S_ROOT + 3;
  localparam int S_WB   = S_ROOT + 4;
  localparam int S_WPOS = S_ROOT + 5;
  localparam int S_H1   = S_ROOT + 6;
  localparam int S_H2   = S_ROOT + 7;
  localparam int S_H3   = S_ROOT + 8;
  localparam int S_EXP  = S_ROOT + 9;
  localparam int S_AG   = S_ROOT + 10;
  localparam int S_DM   = S_ROOT + 11;
  localparam int S_QUOT = S_ROOT + RW;
  localparam int S_PROD = S_QUOT + 1;
  localparam int S_DISP = S_QUOT + 2;
  localparam int S_RES  = S_QUOT + 3;
  localparam int S_OUT  = S_QUOT + 4;

  localparam int RES_W    = 56;
  localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam logic signed [RES_W-1:0] SAT_HI = (RES_W'(1) <<< (SAT_BITS - 1)) - RES_W'(1);
  localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

  function automatic logic [PW-1:0] mag_of(input logic [PW-1:0] v);
    return v[PW-1] ? (~v) + PW'(1) : v;
  endfunction

  // Configuration registers
  logic [1:0]  mode_r;
  logic [31:0] amp_r;
  logic [30:0] max_r;
  logic [30:0] idl_r;
  logic [30:0] wn_r;
  logic [31:0] us_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rsr_pkg::MODE_EXP;
      amp_r  <= '0;
      max_r  <= 31'd65536;
      idl_r  <= 31'd65536;
      wn_r   <= '0;
      us_r   <= 32'd16777216;
    end else if (cfg_we) begin
      case (cfg_index)
        rsr_pkg::REG_MODE:          mode_r <= cfg_wdata[1:0];
        rsr_pkg::REG_AMPLITUDE:     amp_r  <= cfg_wdata;
        rsr_pkg::REG_MAX_RADIUS:    max_r  <= cfg_wdata[30:0];
        rsr_pkg::REG_INV_DECAY:     idl_r  <= cfg_wdata[30:0];
        rsr_pkg::REG_WAVE_NUMBER:   wn_r   <= cfg_wdata[30:0];
        rsr_pkg::REG_UNIFORM_SCALE: us_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control: one enable for all stages
  logic               en;
  logic [S_OUT:1]     vld_r;
  rsr_pkg::side_t     side_r [1:S_RES];

  assign en          = !vld_r[S_OUT] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[S_OUT-1:1], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1].c[0] <= in_ch.pos_x;
      side_r[1].c[1] <= in_ch.pos_y;
      side_r[1].c[2] <= in_ch.pos_z;
      side_r[1].last <= in_ch.last_atom;
      for (int k = 2; k <= S_RES; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Sum of squares
  logic [2:0][PW-1:0]    ac_r;
  logic [2:0][2*PW-1:0]  sq_r;
  logic [2*PW-1:0]       sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ac_r[i] <= mag_of(side_r[1].c[i]);
        sq_r[i] <= (2*PW)'(ac_r[i]) * (2*PW)'(ac_r[i]);
      end
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  logic [RW-1:0] r_w;

  rsr_sqrt #(.IN_W(2*PW)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum_r),
    .root     (r_w)
  );

  // Per-coordinate c/r as Q31 fraction
  logic [2:0][PW-1:0] q_w;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rsr_div #(.W(PW)) u_div (
      .clk   (clk),
      .en    (en),
      .numer (mag_of(side_r[S_ROOT].c[i])),
      .denom (r_w),
      .quot  (q_w[i])
    );
  end

  // Exponent and sine datapath
  logic        rnz_r  [S_DIFF:S_DISP];
  logic        rlt_r  [S_DIFF:S_MAG];
  logic [31:0] absd_r;
  logic [46:0] ang_r;
  logic [46:0] mag_r;
  logic [47:0] pal_r;
  logic [23:0] pah_r;
  logic [23:0] arg_r;
  logic [15:0] phase_r;
  logic [24:0] wb_r;
  logic [16:0] y_r    [S_WB:S_H2];
  logic        qneg_r [S_WB:S_H3];
  logic [24:0] wpos_r [S_WPOS:S_H3];
  logic [16:0] y2_r   [S_WPOS:S_H1];
  logic [14:0] p1_r;
  logic [15:0] s1_r;
  logic [15:0] p2_r;
  logic [16:0] s2_r;
  logic [16:0] m_r;
  logic [16:0] s3_r;
  logic [30:0] e_r    [S_EXP:S_AG];
  logic [16:0] gmag_r;
  logic        gneg_r;
  logic        dneg_r [S_AG:S_DISP];
  logic [32:0] ag_r;
  logic [47:0] dm_r   [S_DM:S_QUOT];

  logic [62:0] angp_w, magp_w;
  logic [53:0] pal_w;
  logic [52:0] pah_w;
  logic [22:0] magc_w;
  logic [47:0] phsum_w;
  logic [54:0] wbp_w;
  logic [14:0] wd_w;
  logic [33:0] yy_w;
  logic [28:0] h1p_w;
  logic [29:0] s1p_w;
  logic [30:0] h2p_w;
  logic [32:0] s2p_w;
  logic [31:0] h3p_w;
  logic [33:0] s3p_w;
  logic [8:0]  nn_w;
  logic [8:0]  rsh_w;
  logic [30:0] e_w;
  logic [48:0] agp_w;
  logic [63:0] dmp_w;

  always_comb begin
    angp_w  = 63'(wn_r) * 63'(r_w);
    magp_w  = 63'(absd_r) * 63'(idl_r);
    pal_w   = 54'(ang_r[23:0]) * 54'(rsr_pkg::INV_TWO_PI_Q32);
    pah_w   = 53'(ang_r[46:24]) * 53'(rsr_pkg::INV_TWO_PI_Q32);
    magc_w  = (mag_r > 47'(rsr_pkg::EXP_ARG_LIMIT)) ? rsr_pkg::EXP_ARG_LIMIT : mag_r[22:0];
    phsum_w = pal_r + {pah_r, 24'd0};
    wbp_w   = 55'(arg_r) * 55'(rsr_pkg::LOG2E_Q30);
    wd_w    = 15'h4000 - {1'b0, phase_r[13:0]};
    yy_w    = 34'(y_r[S_WB]) * 34'(y_r[S_WB]);
    h1p_w   = 29'(rsr_pkg::EXP_C3) * 29'(wpos_r[S_WPOS][15:0]);
    s1p_w   = 30'(rsr_pkg::SIN_A5) * 30'(y2_r[S_WPOS]);
    h2p_w   = 31'(p1_r) * 31'(wpos_r[S_H1][15:0]);
    s2p_w   = 33'(s1_r) * 33'(y2_r[S_H1]);
    h3p_w   = 32'(p2_r) * 32'(wpos_r[S_H2][15:0]);
    s3p_w   = 34'(s2_r) * 34'(y_r[S_H2]);
    nn_w    = wpos_r[S_H3][24:16];
    rsh_w   = rsr_pkg::EXP_N_BIAS - nn_w;
    // 2^n scaling of the mantissa: clip above, flush below
    if (nn_w >= rsr_pkg::EXP_N_BIAS + 9'd15) begin
      e_w = 31'h7FFF_FFFF;
    end else if (nn_w >= rsr_pkg::EXP_N_BIAS) begin
      e_w = 31'(m_r) << nn_w[3:0];
    end else if (rsh_w >= 9'd18) begin
      e_w = '0;
    end else begin
      e_w = 31'(m_r >> rsh_w[4:0]);
    end
    agp_w   = 49'(mag_of(amp_r)) * 49'(gmag_r);
    dmp_w   = 64'(ag_r) * 64'(e_r[S_AG]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // distance to the outer radius, angle
      rnz_r[S_DIFF] <= r_w != '0;
      rlt_r[S_DIFF] <= r_w < {1'b0, max_r};
      absd_r        <= (r_w < {1'b0, max_r}) ? {1'b0, max_r} - r_w : r_w - {1'b0, max_r};
      ang_r         <= angp_w[62:16];
      // exponent argument magnitude, phase partial products
      rlt_r[S_MAG]  <= rlt_r[S_DIFF];
      mag_r         <= magp_w[62:16];
      pal_r         <= pal_w[47:0];
      pah_r         <= pah_w[23:0];
      // biased exponent argument, phase in turns
      arg_r         <= rlt_r[S_MAG] ? 24'(rsr_pkg::EXP_ARG_LIMIT) - 24'(magc_w)
                                    : 24'(rsr_pkg::EXP_ARG_LIMIT) + 24'(magc_w);
      phase_r       <= phsum_w[47:32];
      // base-2 exponent, quarter-wave fold
      wb_r          <= wbp_w[54:30];
      y_r[S_WB]     <= phase_r[14] ? {wd_w, 2'b00} : {1'b0, phase_r[13:0], 2'b00};
      qneg_r[S_WB]  <= phase_r[15];
      wpos_r[S_WPOS] <= wb_r + rsr_pkg::EXP_BIAS;
      y2_r[S_WPOS]   <= yy_w[32:16];
      // Horner steps for 2^f and the odd sine polynomial
      p1_r <= rsr_pkg::EXP_C2 + 15'(h1p_w[28:16]);
      s1_r <= rsr_pkg::SIN_A3 - 16'(s1p_w[29:16]);
      p2_r <= rsr_pkg::EXP_C1 + 16'(h2p_w[30:16]);
      s2_r <= rsr_pkg::SIN_A1 - 17'(s2p_w[32:16]);
      m_r  <= rsr_pkg::ONE_Q16 + 17'(h3p_w[31:16]);
      s3_r <= s3p_w[32:16];
      for (int k = S_WB + 1; k <= S_H2; k++) y_r[k] <= y_r[k-1];
      for (int k = S_WB + 1; k <= S_H3; k++) qneg_r[k] <= qneg_r[k-1];
      for (int k = S_WPOS + 1; k <= S_H3; k++) wpos_r[k] <= wpos_r[k-1];
      for (int k = S_WPOS + 1; k <= S_H1; k++) y2_r[k] <= y2_r[k-1];
      // exp value and g(r); hold exp one more stage to meet amplitude times g
      e_r[S_EXP] <= e_w;
      e_r[S_AG]  <= e_r[S_EXP];
      gmag_r <= (mode_r == rsr_pkg::MODE_OSC) ? s3_r : rsr_pkg::ONE_Q16;
      gneg_r <= (mode_r == rsr_pkg::MODE_OSC) && qneg_r[S_H3] && (s3_r != '0);
      // displacement magnitude and sign
      ag_r          <= agp_w[48:16];
      dneg_r[S_AG]  <= amp_r[31] != gneg_r;
      dm_r[S_DM]    <= dmp_w[63:16];
      for (int k = S_DIFF + 1; k <= S_DISP; k++) rnz_r[k] <= rnz_r[k-1];
      for (int k = S_AG + 1; k <= S_DISP; k++) dneg_r[k] <= dneg_r[k-1];
      for (int k = S_DM + 1; k <= S_QUOT; k++) dm_r[k] <= dm_r[k-1];
    end
  end

  // Per-coordinate displacement, uniform scale, selection, saturation
  logic [2:0][63:0]       p_r;
  logic [2:0][47:0]       t_r;
  logic [2:0][39:0]       um_r [S_PROD:S_DISP];
  logic [2:0][49:0]       disp_r;
  logic [2:0][RES_W-1:0]  res_r;
  logic [2:0][63:0]       p_w;
  logic [2:0][47:0]       t_w;
  logic [2:0][63:0]       ump_w;
  logic [2:0][48:0]       low_w;
  logic [2:0][RES_W-1:0]  res_nxt;
  logic [2:0][PW-1:0]     new_nxt;
  logic                   clip_nxt;

  always_comb begin
    clip_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p_w[i]   = 64'(dm_r[S_QUOT][47:16]) * 64'(q_w[i]);
      t_w[i]   = 48'(dm_r[S_QUOT][15:0]) * 48'(q_w[i]);
      ump_w[i] = 64'(mag_of(side_r[S_QUOT].c[i])) * 64'(us_r);
      low_w[i] = 49'({p_r[i][14:0], 16'd0}) + 49'(t_r[i]);
      case (mode_r)
        rsr_pkg::MODE_EXP, rsr_pkg::MODE_OSC: begin
          if (!rnz_r[S_DISP]) begin
            res_nxt[i] = RES_W'($signed(side_r[S_DISP].c[i]));
          end else if (side_r[S_DISP].c[i][PW-1] != dneg_r[S_DISP]) begin
            res_nxt[i] = RES_W'($signed(side_r[S_DISP].c[i])) - RES_W'(disp_r[i]);
          end else begin
            res_nxt[i] = RES_W'($signed(side_r[S_DISP].c[i])) + RES_W'(disp_r[i]);
          end
        end
        rsr_pkg::MODE_UNIFORM: begin
          res_nxt[i] = side_r[S_DISP].c[i][PW-1] ? -RES_W'(um_r[S_DISP][i])
                                                 : RES_W'(um_r[S_DISP][i]);
        end
        default: begin
          res_nxt[i] = RES_W'($signed(side_r[S_DISP].c[i]));
        end
      endcase
      // clip to the coordinate range
      if ($signed(res_r[i]) > SAT_HI) begin
        new_nxt[i] = SAT_HI[PW-1:0];
        clip_nxt   = 1'b1;
      end else if ($signed(res_r[i]) < SAT_LO) begin
        new_nxt[i] = SAT_LO[PW-1:0];
        clip_nxt   = 1'b1;
      end else begin
        new_nxt[i] = res_r[i][PW-1:0];
      end
    end
  end

  logic [2:0][PW-1:0] new_r;
  logic               final_r;
  logic               sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i]    <= p_w[i];
        t_r[i]    <= t_w[i];
        disp_r[i] <= 50'(p_r[i][63:15]) + 50'(low_w[i][48:31]);
      end
      um_r[S_PROD] <= {ump_w[2][63:24], ump_w[1][63:24], ump_w[0][63:24]};
      um_r[S_DISP] <= um_r[S_PROD];
      res_r   <= res_nxt;
      new_r   <= new_nxt;
      final_r <= side_r[S_RES].last;
      sat_r   <= clip_nxt;
    end
  end

  assign out_ch.valid      = vld_r[S_OUT];
  assign out_ch.new_x      = new_r[0];
  assign out_ch.new_y      = new_r[1];
  assign out_ch.new_z      = new_r[2];
  assign out_ch.final_atom = final_r;
  assign out_ch.saturated  = sat_r;

endmodule

/* rtl/rsr_checker.sv */
// Port-level checker for the radial surface relaxation block, with its bind.
// Depends on rsr_pkg; attaches to radial_surface_relaxation.
module rsr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rsr_pkg::POS_W-1:0] new_x,
  input logic [rsr_pkg::POS_W-1:0] new_y,
  input logic [rsr_pkg::POS_W-1:0] new_z,
  input logic                      final_atom,
  input logic                      saturated
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(new_x) && $stable(new_y)
      && $stable(new_z) && $stable(final_atom) && $stable(saturated))
    else $error("result changed while stalled");

  // input side stalls exactly when a result waits untaken
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in ready does not follow output stall");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // nothing comes out of a pipe that saw no transfer during reset
  a_no_early: assert property (@(posedge clk)
    !rst_n && !in_valid |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind radial_surface_relaxation rsr_checker u_rsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .new_x      (out_ch.new_x),
  .new_y      (out_ch.new_y),
  .new_z      (out_ch.new_z),
  .final_atom (out_ch.final_atom),
  .saturated  (out_ch.saturated)
);
